// ===== hdl/cdad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int YMOD_W  = 9;   // year modulo the leap cycle, 0..399

    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 16'd2000;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    // 2000 sits at the start of a leap cycle
    localparam logic [YMOD_W-1:0]  RESET_YMOD  = 9'd0;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    localparam logic [YMOD_W-1:0] LEAP_CYCLE = 9'd400;
    localparam logic [YMOD_W-1:0] CENTURY_1  = 9'd100;
    localparam logic [YMOD_W-1:0] CENTURY_2  = 9'd200;
    localparam logic [YMOD_W-1:0] CENTURY_3  = 9'd300;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] REG_START_YEAR  = 2'd0;
    localparam logic [1:0] REG_START_MONTH = 2'd1;
    localparam logic [1:0] REG_START_DAY   = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } cdad_date_t;

    typedef struct packed {
        logic               fits;   // remaining days end inside this month
        cdad_date_t         date;   // date after this step
        logic [YMOD_W-1:0]  ymod;   // leap-cycle position after this step
        logic [COUNT_W-1:0] left;   // days still to add after this step
    } cdad_step_t;

    // Leap test from the position inside the 400-year cycle
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        is_leap = (ymod[1:0] == 2'b00) && (ymod != CENTURY_1) &&
                  (ymod != CENTURY_2) && (ymod != CENTURY_3);
    endfunction

    // Month length; month is expected in 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

// ===== hdl/cdad_month_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_month_step
// One step of the date walk: either finish inside the current month or
// move to the first day of the next month, charging the days used.
// ----------------------------------------------------------------------------
module cdad_month_step
    import cdad_pkg::*;
(
    input  cdad_date_t         date,
    input  logic [YMOD_W-1:0]  ymod,
    input  logic [COUNT_W-1:0] left,
    output cdad_step_t         step
);

    logic [DAY_W-1:0]   len;
    logic [COUNT_W:0]   sum;
    logic [DAY_W:0]     used;

    // Compare the target day against the month length
    assign len  = month_len(date.month, is_leap(ymod));
    assign sum  = {1'b0, left} + {{(COUNT_W+1-DAY_W){1'b0}}, date.day};
    assign used = {1'b0, len} - {1'b0, date.day} + {{DAY_W{1'b0}}, 1'b1};

    always_comb
    begin
        step.fits = (sum <= {{(COUNT_W+1-DAY_W){1'b0}}, len});
        step.date = date;
        step.ymod = ymod;
        step.left = left;
        if (step.fits)
        begin
            // Land inside this month
            step.date.day = sum[DAY_W-1:0];
            step.left     = '0;
        end
        else
        begin
            // Advance to day one of the next month
            step.date.day = 5'd1;
            step.left     = left - {{(COUNT_W-DAY_W-1){1'b0}}, used};
            if (date.month >= DECEMBER)
            begin
                step.date.month = JANUARY;
                step.date.year  = date.year + 16'd1;
                if (date.year == YEAR_MAX || ymod == LEAP_CYCLE - 9'd1)
                    step.ymod = '0;
                else
                    step.ymod = ymod + 9'd1;
            end
            else
            begin
                step.date.month = date.month + 4'd1;
            end
        end
    end

endmodule

// ===== hdl/calendar_date_add_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days
// Gregorian date accumulator that adds a day count to a held date.
// ----------------------------------------------------------------------------
// The block holds a date (year, month, day) and adds day_count days to it for
// each input transfer, then presents the new date as one output transfer.
// It walks one month per clock through a shared month-step unit, finishing
// once the output register is free. With restart set the date is first
// reloaded from the start registers: the start year is reduced into the
// 400-year leap cycle by shift-and-subtract, then the start day is clamped
// to the month length. in_ready is high only while no item is in progress; a
// finished date waits in the output register, and a new item can be taken
// meanwhile. The year wraps modulo 65536; configuration writes are always
// accepted and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module calendar_date_add_days
    import cdad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [YEAR_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    input  logic [COUNT_W-1:0]  day_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [YEAR_W-1:0]   year_out,
    output logic [MONTH_W-1:0]  month_out,
    output logic [DAY_W-1:0]    day_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_CLAMP  = 2'd2;
    localparam logic [1:0] ST_WALK   = 2'd3;

    logic [1:0]          state_reg,  state_next;
    logic [YEAR_W-1:0]   start_year_reg;
    logic [MONTH_W-1:0]  start_month_reg;
    logic [DAY_W-1:0]    start_day_reg;
    cdad_date_t          cur_reg,    cur_next;
    logic [YEAR_W-1:0]   ymod_reg,   ymod_next;
    logic [COUNT_W-1:0]  left_reg,   left_next;
    logic [2:0]          shift_reg,  shift_next;
    logic                out_valid_reg, out_valid_next;
    cdad_date_t          out_reg,    out_next;

    cdad_step_t          step;
    logic [YEAR_W-1:0]   sub_val;
    logic [DAY_W-1:0]    clamp_len;
    logic                can_emit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign year_out  = out_reg.year;
    assign month_out = out_reg.month;
    assign day_out   = out_reg.day;

    // Shared month-step unit
    cdad_month_step u_step (
        .date (cur_reg),
        .ymod (ymod_reg[YMOD_W-1:0]),
        .left (left_reg),
        .step (step)
    );

    // Leap-cycle reduction subtrahend and month length for the day clamp
    assign sub_val   = {{(YEAR_W-YMOD_W){1'b0}}, LEAP_CYCLE} << shift_reg;
    assign clamp_len = month_len(cur_reg.month, is_leap(ymod_reg[YMOD_W-1:0]));
    assign can_emit  = !out_valid_reg || out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_year_reg  <= RESET_YEAR;
            start_month_reg <= RESET_MONTH;
            start_day_reg   <= RESET_DAY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_YEAR:  start_year_reg  <= cfg_data;
                REG_START_MONTH: start_month_reg <= cfg_data[MONTH_W-1:0];
                REG_START_DAY:   start_day_reg   <= cfg_data[DAY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ymod_next      = ymod_reg;
        left_next      = left_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    left_next = day_count;
                    if (restart)
                    begin
                        // Load the start date, month clamped to 1..12
                        cur_next.year = start_year_reg;
                        cur_next.day  = start_day_reg;
                        if (start_month_reg < JANUARY)
                            cur_next.month = JANUARY;
                        else if (start_month_reg > DECEMBER)
                            cur_next.month = DECEMBER;
                        else
                            cur_next.month = start_month_reg;
                        ymod_next  = start_year_reg;
                        shift_next = 3'd7;
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_REDUCE:
            begin
                // Drop one shifted multiple of the leap cycle per cycle
                if (ymod_reg >= sub_val)
                    ymod_next = ymod_reg - sub_val;
                shift_next = shift_reg - 3'd1;
                if (shift_reg == 3'd0)
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // Keep the start day inside the loaded month
                if (cur_reg.day == '0)
                    cur_next.day = 5'd1;
                else if (cur_reg.day > clamp_len)
                    cur_next.day = clamp_len;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (!step.fits)
                begin
                    cur_next  = step.date;
                    ymod_next = {{(YEAR_W-YMOD_W){1'b0}}, step.ymod};
                    left_next = step.left;
                end
                else if (can_emit)
                begin
                    cur_next       = step.date;
                    left_next      = step.left;
                    out_next       = step.date;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and date state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg.year  <= RESET_YEAR;
            cur_reg.month <= RESET_MONTH;
            cur_reg.day   <= RESET_DAY;
            ymod_reg      <= {{(YEAR_W-YMOD_W){1'b0}}, RESET_YMOD};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            ymod_reg      <= ymod_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

`ifndef SYNTHESIS
    // An accepted item blocks the input until the walk is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // Held month stays a real month
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg.month >= JANUARY) && (cur_reg.month <= DECEMBER))
        else $error("month out of range");

    // Leap-cycle position is reduced outside the reduction pass
    a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_REDUCE) |->
        (ymod_reg < {{(YEAR_W-YMOD_W){1'b0}}, LEAP_CYCLE}))
        else $error("leap-cycle position not reduced");

    // Day is valid for its month whenever walking
    a_day_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cur_reg.day != '0) && (cur_reg.day <= clamp_len))
        else $error("day outside month during walk");

    // A new result only comes out of the walk
    a_emit_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_WALK))
        else $error("result raised outside the walk");
`endif

endmodule

// ===== bench/calendar_date_add_days_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_tb
// Self-checking bench for the Gregorian date accumulator.
// ----------------------------------------------------------------------------
// A directed pass covers the reset date, leap and century rules, the clamping
// of out-of-range start registers, the year wrap, the unused register index
// and the largest day counts. Random traffic follows in three idle settings.
// Every accepted transfer is run through an in-bench calendar model. The
// returned date is compared field by field with the oldest expected date.
// ----------------------------------------------------------------------------
module calendar_date_add_days_tb;
    import cdad_pkg::*;

    localparam logic [1:0]         REG_UNUSED    = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam int                 SMALL_MAX     = 400;
    localparam int                 SETTLE_CYCLES = 4;
    // run bound for about 40 long items plus short ones and stalls
    localparam int                 CYCLE_LIMIT   = 1_000_000;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [YEAR_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                restart;
    logic [COUNT_W-1:0]  day_count;
    logic                out_valid;
    logic                out_ready;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;

    // Calendar model state: start registers and the date currently held
    logic [YEAR_W-1:0]   start_year_r  = RESET_YEAR;
    logic [MONTH_W-1:0]  start_month_r = RESET_MONTH;
    logic [DAY_W-1:0]    start_day_r   = RESET_DAY;
    cdad_date_t          held_date     = '{year: RESET_YEAR, month: RESET_MONTH,
                                           day: RESET_DAY};

    cdad_date_t          pending_dates[$];

    int                  src_idle_pct  = 35;
    int                  sink_idle_pct = 49;
    int                  error_count   = 0;
    int                  items_sent    = 0;
    int                  restarts_sent = 0;
    int                  long_counts   = 0;
    int                  results_seen  = 0;
    int                  cfg_writes    = 0;
    int                  cycle_count   = 0;

    calendar_date_add_days u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .day_count (day_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .year_out  (year_out),
        .month_out (month_out),
        .day_out   (day_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Full Gregorian rule on the 16-bit year
    function automatic bit leap_year(input logic [YEAR_W-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m);
        case (m)
            FEBRUARY:                return leap_year(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    // Reload on restart, then walk forward one month at a time
    function automatic cdad_date_t advance_date(input logic rs,
                                                input logic [COUNT_W-1:0] cnt);
        int unsigned remaining;
        int unsigned len;
        remaining = cnt;
        if (rs)
        begin
            held_date.year = start_year_r;
            if (start_month_r < JANUARY)
                held_date.month = JANUARY;
            else if (start_month_r > DECEMBER)
                held_date.month = DECEMBER;
            else
                held_date.month = start_month_r;
            len = month_days(held_date.year, held_date.month);
            if (start_day_r == 0)
                held_date.day = 5'd1;
            else if (start_day_r > len)
                held_date.day = DAY_W'(len);
            else
                held_date.day = start_day_r;
        end
        len = month_days(held_date.year, held_date.month);
        while (held_date.day + remaining > len)
        begin
            remaining = remaining - (len - held_date.day + 1);
            held_date.day = 5'd1;
            if (held_date.month == DECEMBER)
            begin
                held_date.month = JANUARY;
                held_date.year  = held_date.year + 16'd1;
            end
            else
                held_date.month = held_date.month + 4'd1;
            len = month_days(held_date.year, held_date.month);
        end
        held_date.day = DAY_W'(held_date.day + remaining);
        return held_date;
    endfunction

    // Hold off until every expected date has come back
    task automatic wait_idle();
        while (pending_dates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one start register while the block is idle
    task automatic write_start_reg(input logic [1:0] idx, input logic [YEAR_W-1:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_START_YEAR:  start_year_r  = data;
            REG_START_MONTH: start_month_r = data[MONTH_W-1:0];
            REG_START_DAY:   start_day_r   = data[DAY_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one day count; predict its date at the accepting edge
    task automatic send_days(input logic rs, input logic [COUNT_W-1:0] cnt);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        restart   = rs;
        day_count = cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_dates.push_back(advance_date(rs, cnt));
        items_sent++;
        if (rs)
            restarts_sent++;
        if (cnt > SMALL_MAX)
            long_counts++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest expected date
    initial
    begin : result_checker
        cdad_date_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                results_seen++;
                if (pending_dates.size() == 0)
                begin
                    $display("%0t ns: unexpected date %0d-%0d-%0d", $time,
                             year_out, month_out, day_out);
                    error_count++;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    check_field("year", want.year, year_out);
                    check_field("month", want.month, month_out);
                    check_field("day", want.day, day_out);
                end
            end
            @(negedge clk);
            out_ready = (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d dates outstanding", cycle_count,
                 pending_dates.size());
        $display("calendar_date_add_days_tb: errors");
        $finish;
    end

    // Reset date, zero days, leap day of a 400-year, then a plain restart
    task automatic test_reset_date();
        send_days(1'b0, 16'd0);
        send_days(1'b0, 16'd31);
        send_days(1'b0, 16'd28);
        send_days(1'b0, 16'd1);
        send_days(1'b1, 16'd0);
    endtask

    // Out-of-range start month and day, non-leap century, 30-day month
    task automatic test_start_clamping();
        write_start_reg(REG_START_YEAR, 16'd2100);
        write_start_reg(REG_START_MONTH, 16'(FEBRUARY));
        write_start_reg(REG_START_DAY, 16'd31);
        send_days(1'b1, 16'd0);
        send_days(1'b0, 16'd1);
        write_start_reg(REG_START_MONTH, 16'd0);
        write_start_reg(REG_START_DAY, 16'd0);
        send_days(1'b1, 16'd0);
        write_start_reg(REG_START_MONTH, 16'd4);
        write_start_reg(REG_START_DAY, 16'd31);
        send_days(1'b1, 16'd0);
    endtask

    // Last day of the last year, roll into year 0 and its leap day
    task automatic test_year_wrap();
        write_start_reg(REG_START_YEAR, YEAR_MAX);
        write_start_reg(REG_START_MONTH, 16'd15);
        write_start_reg(REG_START_DAY, 16'd31);
        send_days(1'b1, 16'd0);
        send_days(1'b0, 16'd1);
        send_days(1'b0, 16'd59);
    endtask

    // Maximum counts from both ends of the year range
    task automatic test_long_counts();
        write_start_reg(REG_START_MONTH, 16'd13);
        send_days(1'b1, COUNT_MAX);
        write_start_reg(REG_START_YEAR, 16'd0);
        write_start_reg(REG_START_MONTH, 16'(FEBRUARY));
        write_start_reg(REG_START_DAY, 16'd30);
        send_days(1'b1, 16'd0);
        send_days(1'b1, COUNT_MAX);
        send_days(1'b0, COUNT_MAX);
    endtask

    // A write to the spare index must leave the start date alone
    task automatic test_unused_register();
        write_start_reg(REG_UNUSED, 16'hFFFF);
        send_days(1'b1, 16'd0);
        write_start_reg(REG_UNUSED, 16'h0000);
        send_days(1'b1, 16'd1);
    endtask

    // Random counts, mostly short; occasional register rewrites and drains
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int count);
        int                 k;
        int                 pick;
        logic [1:0]         idx;
        logic [YEAR_W-1:0]  data;
        logic [COUNT_W-1:0] cnt;
        logic               rs;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                idx = 2'($urandom_range(3));
                case ($urandom_range(3))
                    0:       data = 16'h0000;
                    1:       data = YEAR_MAX;
                    2:       data = 16'($urandom_range(31));
                    default: data = 16'($urandom());
                endcase
                write_start_reg(idx, data);
            end
            else if (pick < 9 || k == count / 2)
                wait_idle();
            rs   = ($urandom_range(3) == 0);
            pick = $urandom_range(99);
            if (pick < 80)
                cnt = 16'($urandom_range(SMALL_MAX));
            else if (pick < 85)
                cnt = COUNT_MAX;
            else if (pick < 90)
                cnt = 16'd0;
            else
                cnt = 16'($urandom());
            send_days(rs, cnt);
        end
    endtask

    initial
    begin : run_tests
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_START_YEAR;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        day_count = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_date();
        test_start_clamping();
        test_year_wrap();
        test_long_counts();
        test_unused_register();
        test_random_traffic(35, 49, 90);
        test_random_traffic(49, 35, 90);
        test_random_traffic(0, 0, 90);
        wait_idle();

        $display("covered %0d day counts (%0d with restart, %0d long), %0d dates checked,",
                 items_sent, restarts_sent, long_counts, results_seen);
        $display("%0d start register writes, %0d cycles", cfg_writes, cycle_count);
        if (error_count == 0)
            $display("calendar_date_add_days_tb: clean");
        else
            $display("calendar_date_add_days_tb: errors");
        $finish;
    end

endmodule

// ===== calendar_date_add_days.f =====
hdl/cdad_pkg.sv
hdl/cdad_month_step.sv
hdl/calendar_date_add_days.sv
bench/calendar_date_add_days_tb.sv
